[rtl/rau_pkg.sv]
package rau_pkg;

  // Opcodes; the unused code 7 behaves as reduce
  localparam logic [2:0] OP_REDUCE = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_CMP    = 3'd5;
  localparam logic [2:0] OP_POW    = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_ANBD,
    CMD_MUL_BNAD,
    CMD_MUL_ANBN,
    CMD_MUL_ADBN,
    CMD_MUL_ADBD,
    CMD_COMBINE,
    CMD_COMPARE,
    CMD_LOAD_A,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_INIT_X,
    CMD_DIV_INIT_Y,
    CMD_DIV_STEP,
    CMD_DIV_WB_X,
    CMD_DIV_WB_Y,
    CMD_POW_INIT,
    CMD_POW_MUL_N,
    CMD_POW_MUL_D,
    CMD_POW_SQ_N,
    CMD_POW_SQ_D,
    CMD_POW_FIN,
    CMD_FINAL
  } cmd_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMB,
    S_CMP,
    S_LDA,
    S_GINIT,
    S_GSTEP,
    S_DXI,
    S_DXS,
    S_DXD,
    S_DYI,
    S_DYS,
    S_DYD,
    S_PINIT,
    S_PCHK,
    S_PMN,
    S_PMD,
    S_PSN,
    S_PSD,
    S_PFIN,
    S_FINAL
  } state_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       early;     // zero denominator or division by zero
    logic       x_zero;
    logic       g_eq;
    logic       g_one;
    logic       div_last;
    logic       e_zero;
    logic       e_lsb;
    logic       out_busy;
  } stat_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_opcode, in_a_num, in_a_den, in_b_num, in_b_den, in_exponent
// out       out_valid / out_ready out_res_num, out_res_den, out_is_integer, out_equal,
//                                 out_less, out_status
//
// One item at a time. Zero-denominator and division-by-zero cases go straight to the result,
// and compare needs no reduction. Other opcodes run one binary gcd step per cycle and,
// unless the gcd is one, two restoring divisions; power then adds up to 32 rounds on the
// single 32x32 multiplier.
// Reset (rst_n, synchronous, active low) clears the controller and the output valid.
// A result beat waits in the output register; the next item is taken meanwhile, and only
// its own result waits while out_ready is low.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  input  logic signed [31:0] in_exponent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_is_integer,
  output logic               out_equal,
  output logic               out_less,
  output logic [1:0]         out_status
);

  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_opcode),
    .in_a_num       (in_a_num),
    .in_a_den       (in_a_den),
    .in_b_num       (in_b_num),
    .in_b_den       (in_b_den),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res_num    (out_res_num),
    .out_res_den    (out_res_den),
    .out_is_integer (out_is_integer),
    .out_equal      (out_equal),
    .out_less       (out_less),
    .out_status     (out_status)
  );

endmodule

[rtl/rau_ctrl.sv]
module rau_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rau_pkg::stat_t stat,
  output rau_pkg::cmd_t  cmd
);

  rau_pkg::state_t state_r, state_nxt;
  rau_pkg::state_t post_reduce;
  logic            three_mul;

  // after a reduction: power continues, everything else finishes
  assign post_reduce = (stat.op == rau_pkg::OP_POW) ? rau_pkg::S_PINIT : rau_pkg::S_FINAL;
  assign three_mul   = (stat.op == rau_pkg::OP_ADD) || (stat.op == rau_pkg::OP_SUB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::S_IDLE:  if (in_valid) state_nxt = rau_pkg::S_DISP;
      rau_pkg::S_DISP: begin
        if (stat.early) begin
          state_nxt = rau_pkg::S_FINAL;
        end else if (stat.op >= rau_pkg::OP_ADD && stat.op <= rau_pkg::OP_CMP) begin
          state_nxt = rau_pkg::S_MUL1;
        end else begin
          state_nxt = rau_pkg::S_LDA;
        end
      end
      rau_pkg::S_MUL1:  state_nxt = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: begin
        if (three_mul) state_nxt = rau_pkg::S_MUL3;
        else if (stat.op == rau_pkg::OP_CMP) state_nxt = rau_pkg::S_CMP;
        else state_nxt = rau_pkg::S_COMB;
      end
      rau_pkg::S_MUL3:  state_nxt = rau_pkg::S_COMB;
      rau_pkg::S_CMP:   state_nxt = rau_pkg::S_FINAL;
      rau_pkg::S_COMB:  state_nxt = rau_pkg::S_GINIT;
      rau_pkg::S_LDA:   state_nxt = rau_pkg::S_GINIT;
      rau_pkg::S_GINIT: state_nxt = stat.x_zero ? post_reduce : rau_pkg::S_GSTEP;
      rau_pkg::S_GSTEP: begin
        if (stat.g_eq) state_nxt = stat.g_one ? post_reduce : rau_pkg::S_DXI;
      end
      rau_pkg::S_DXI:   state_nxt = rau_pkg::S_DXS;
      rau_pkg::S_DXS:   if (stat.div_last) state_nxt = rau_pkg::S_DXD;
      rau_pkg::S_DXD:   state_nxt = rau_pkg::S_DYI;
      rau_pkg::S_DYI:   state_nxt = rau_pkg::S_DYS;
      rau_pkg::S_DYS:   if (stat.div_last) state_nxt = rau_pkg::S_DYD;
      rau_pkg::S_DYD:   state_nxt = post_reduce;
      rau_pkg::S_PINIT: state_nxt = rau_pkg::S_PCHK;
      rau_pkg::S_PCHK: begin
        if (stat.e_zero) state_nxt = rau_pkg::S_PFIN;
        else if (stat.e_lsb) state_nxt = rau_pkg::S_PMN;
        else state_nxt = rau_pkg::S_PSN;
      end
      rau_pkg::S_PMN:   state_nxt = rau_pkg::S_PMD;
      rau_pkg::S_PMD:   state_nxt = rau_pkg::S_PSN;
      rau_pkg::S_PSN:   state_nxt = rau_pkg::S_PSD;
      rau_pkg::S_PSD:   state_nxt = rau_pkg::S_PCHK;
      rau_pkg::S_PFIN:  state_nxt = rau_pkg::S_FINAL;
      rau_pkg::S_FINAL: if (!stat.out_busy) state_nxt = rau_pkg::S_IDLE;
      default:          state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = rau_pkg::CMD_NONE;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = rau_pkg::CMD_LOAD;
      end
      rau_pkg::S_MUL1: begin
        cmd = (stat.op == rau_pkg::OP_MUL) ? rau_pkg::CMD_MUL_ANBN : rau_pkg::CMD_MUL_ANBD;
      end
      rau_pkg::S_MUL2: begin
        if (stat.op == rau_pkg::OP_MUL) cmd = rau_pkg::CMD_MUL_ADBD;
        else if (stat.op == rau_pkg::OP_DIV) cmd = rau_pkg::CMD_MUL_ADBN;
        else cmd = rau_pkg::CMD_MUL_BNAD;
      end
      rau_pkg::S_MUL3:  cmd = rau_pkg::CMD_MUL_ADBD;
      rau_pkg::S_COMB:  cmd = rau_pkg::CMD_COMBINE;
      rau_pkg::S_CMP:   cmd = rau_pkg::CMD_COMPARE;
      rau_pkg::S_LDA:   cmd = rau_pkg::CMD_LOAD_A;
      rau_pkg::S_GINIT: cmd = rau_pkg::CMD_GCD_INIT;
      rau_pkg::S_GSTEP: cmd = stat.g_eq ? rau_pkg::CMD_NONE : rau_pkg::CMD_GCD_STEP;
      rau_pkg::S_DXI:   cmd = rau_pkg::CMD_DIV_INIT_X;
      rau_pkg::S_DXS:   cmd = rau_pkg::CMD_DIV_STEP;
      rau_pkg::S_DXD:   cmd = rau_pkg::CMD_DIV_WB_X;
      rau_pkg::S_DYI:   cmd = rau_pkg::CMD_DIV_INIT_Y;
      rau_pkg::S_DYS:   cmd = rau_pkg::CMD_DIV_STEP;
      rau_pkg::S_DYD:   cmd = rau_pkg::CMD_DIV_WB_Y;
      rau_pkg::S_PINIT: cmd = rau_pkg::CMD_POW_INIT;
      rau_pkg::S_PMN:   cmd = rau_pkg::CMD_POW_MUL_N;
      rau_pkg::S_PMD:   cmd = rau_pkg::CMD_POW_MUL_D;
      rau_pkg::S_PSN:   cmd = rau_pkg::CMD_POW_SQ_N;
      rau_pkg::S_PSD:   cmd = rau_pkg::CMD_POW_SQ_D;
      rau_pkg::S_PFIN:  cmd = rau_pkg::CMD_POW_FIN;
      rau_pkg::S_FINAL: cmd = stat.out_busy ? rau_pkg::CMD_NONE : rau_pkg::CMD_FINAL;
      default:          cmd = rau_pkg::CMD_NONE;
    endcase
  end

endmodule

[rtl/rau_datapath.sv]
module rau_datapath #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rau_pkg::cmd_t       cmd,
  output rau_pkg::stat_t      stat,
  input  logic [2:0]          in_opcode,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  input  logic signed [31:0]  in_exponent,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic                out_is_integer,
  output logic                out_equal,
  output logic                out_less,
  output logic [1:0]          out_status
);

  localparam int          WEFF = (WIDTH > 32) ? 32 : WIDTH;
  localparam logic [63:0] LIM  = 64'd1 << (WEFF - 1);

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // operand magnitudes and signs
  logic [2:0]  op_r;
  logic [31:0] an_r, ad_r, bn_r, bd_r, em_r;
  logic        an_s_r, ad_s_r, bn_s_r, bd_s_r, e_s_r;
  // working fraction and scratch products
  logic [63:0] t1_r, t2_r, x_r, y_r;
  logic        neg_r, eq_r, lt_r, big_r;
  // gcd
  logic [63:0] u_r, v_r, u_nxt, v_nxt;
  logic [5:0]  k_r, k_nxt;
  // divider
  logic [63:0] dq_r, dv_r, dq_nxt;
  logic [64:0] rem_r, rem_nxt, rem_sh;
  logic [5:0]  cnt_r;
  // power
  logic [31:0] pn_r, pd_r, rn_r, rd_r, e_r;
  logic        pnb_r, pdb_r, rnb_r, rdb_r;
  // output beat
  logic        out_valid_r;
  logic [31:0] res_num_r;
  logic [30:0] res_den_r;
  logic        is_int_r, eq_o_r, lt_o_r;
  logic [1:0]  status_r;

  // special cases
  logic uses_b, zden, divz;
  assign uses_b = (op_r >= rau_pkg::OP_ADD) && (op_r <= rau_pkg::OP_CMP);
  assign zden   = (ad_r == 32'd0) || (uses_b && (bd_r == 32'd0));
  assign divz   = ((op_r == rau_pkg::OP_DIV) && (bn_r == 32'd0)) ||
                  ((op_r == rau_pkg::OP_POW) && e_s_r && (an_r == 32'd0));

  // shared multiplier with saturation for power
  logic [31:0] ma, mb, sat_val;
  logic        ma_big, mb_big, sat_big;
  logic [63:0] prod;
  always_comb begin
    ma = an_r; mb = bd_r; ma_big = 1'b0; mb_big = 1'b0;
    unique case (cmd)
      rau_pkg::CMD_MUL_BNAD:  begin ma = bn_r; mb = ad_r; end
      rau_pkg::CMD_MUL_ANBN:  begin ma = an_r; mb = bn_r; end
      rau_pkg::CMD_MUL_ADBN:  begin ma = ad_r; mb = bn_r; end
      rau_pkg::CMD_MUL_ADBD:  begin ma = ad_r; mb = bd_r; end
      rau_pkg::CMD_POW_MUL_N: begin ma = rn_r; mb = pn_r; ma_big = rnb_r; mb_big = pnb_r; end
      rau_pkg::CMD_POW_MUL_D: begin ma = rd_r; mb = pd_r; ma_big = rdb_r; mb_big = pdb_r; end
      rau_pkg::CMD_POW_SQ_N:  begin ma = pn_r; mb = pn_r; ma_big = pnb_r; mb_big = pnb_r; end
      rau_pkg::CMD_POW_SQ_D:  begin ma = pd_r; mb = pd_r; ma_big = pdb_r; mb_big = pdb_r; end
      default:                begin ma = an_r; mb = bd_r; end
    endcase
  end
  assign prod    = 64'(ma) * 64'(mb);
  assign sat_big = ((ma_big || mb_big) && (prod != 64'd0)) || (prod[63:32] != 32'd0);
  assign sat_val = sat_big ? 32'hFFFF_FFFF : prod[31:0];

  // signed-magnitude add of the two cross products
  logic        sa, b_neg, sb, sm_s;
  logic [63:0] sm_m;
  assign sa    = an_s_r ^ ad_s_r;
  assign b_neg = bn_s_r ^ bd_s_r;
  assign sb    = ((op_r == rau_pkg::OP_SUB) || (op_r == rau_pkg::OP_CMP)) ? !b_neg : b_neg;
  always_comb begin
    if (sa == sb) begin
      sm_s = sa; sm_m = t1_r + t2_r;
    end else if (t1_r >= t2_r) begin
      sm_s = sa; sm_m = t1_r - t2_r;
    end else begin
      sm_s = sb; sm_m = t2_r - t1_r;
    end
  end

  // binary gcd, one step a cycle
  always_comb begin
    u_nxt = u_r; v_nxt = v_r; k_nxt = k_r;
    priority if (u_r == v_r) begin
      u_nxt = u_r;
    end else if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1; v_nxt = v_r >> 1; k_nxt = k_r + 6'd1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r > v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh  = {rem_r[63:0], dq_r[63]};
  always_comb begin
    if (rem_sh >= {1'b0, dv_r}) begin
      rem_nxt = rem_sh - {1'b0, dv_r};
      dq_nxt  = {dq_r[62:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      dq_nxt  = {dq_r[62:0], 1'b0};
    end
  end

  // range check and result status
  logic       fits;
  logic [1:0] st;
  assign fits = !big_r && (y_r != 64'd0) && (y_r <= LIM - 64'd1) &&
                (neg_r ? (x_r <= LIM) : (x_r <= LIM - 64'd1));
  always_comb begin
    priority if (zden) st = rau_pkg::ST_ZDEN;
    else if (divz) st = rau_pkg::ST_DIVZ;
    else if (op_r == rau_pkg::OP_CMP) st = rau_pkg::ST_OK;
    else if (!fits) st = rau_pkg::ST_OVF;
    else st = rau_pkg::ST_OK;
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      rau_pkg::CMD_LOAD: begin
        op_r   <= in_opcode;
        an_r   <= mag32(in_a_num);    an_s_r <= in_a_num[31];
        ad_r   <= mag32(in_a_den);    ad_s_r <= in_a_den[31];
        bn_r   <= mag32(in_b_num);    bn_s_r <= in_b_num[31];
        bd_r   <= mag32(in_b_den);    bd_s_r <= in_b_den[31];
        em_r   <= mag32(in_exponent); e_s_r  <= in_exponent[31];
        eq_r   <= 1'b0;
        lt_r   <= 1'b0;
        big_r  <= 1'b0;
      end
      rau_pkg::CMD_MUL_ANBD, rau_pkg::CMD_MUL_ANBN: t1_r <= prod;
      rau_pkg::CMD_MUL_BNAD:                        t2_r <= prod;
      rau_pkg::CMD_MUL_ADBN, rau_pkg::CMD_MUL_ADBD: y_r  <= prod;
      rau_pkg::CMD_COMBINE: begin
        if ((op_r == rau_pkg::OP_ADD) || (op_r == rau_pkg::OP_SUB)) begin
          x_r <= sm_m; neg_r <= sm_s;
        end else begin
          x_r <= t1_r; neg_r <= sa ^ b_neg;
        end
      end
      rau_pkg::CMD_COMPARE: begin
        eq_r <= (sm_m == 64'd0);
        lt_r <= (sm_m != 64'd0) && sm_s;
      end
      rau_pkg::CMD_LOAD_A: begin
        x_r <= {32'd0, an_r}; y_r <= {32'd0, ad_r}; neg_r <= sa;
      end
      rau_pkg::CMD_GCD_INIT: begin
        if (x_r == 64'd0) y_r <= 64'd1;
        u_r <= x_r; v_r <= y_r; k_r <= 6'd0;
      end
      rau_pkg::CMD_GCD_STEP: begin
        u_r <= u_nxt; v_r <= v_nxt; k_r <= k_nxt;
      end
      rau_pkg::CMD_DIV_INIT_X: begin
        dq_r <= x_r; rem_r <= 65'd0; dv_r <= u_r << k_r; cnt_r <= 6'd0;
      end
      rau_pkg::CMD_DIV_INIT_Y: begin
        dq_r <= y_r; rem_r <= 65'd0; dv_r <= u_r << k_r; cnt_r <= 6'd0;
      end
      rau_pkg::CMD_DIV_STEP: begin
        dq_r <= dq_nxt; rem_r <= rem_nxt; cnt_r <= cnt_r + 6'd1;
      end
      rau_pkg::CMD_DIV_WB_X: x_r <= dq_r;
      rau_pkg::CMD_DIV_WB_Y: y_r <= dq_r;
      rau_pkg::CMD_POW_INIT: begin
        e_r   <= em_r;
        pn_r  <= e_s_r ? y_r[31:0] : x_r[31:0];
        pd_r  <= e_s_r ? x_r[31:0] : y_r[31:0];
        rn_r  <= 32'd1; rd_r <= 32'd1;
        pnb_r <= 1'b0; pdb_r <= 1'b0; rnb_r <= 1'b0; rdb_r <= 1'b0;
        neg_r <= sa & em_r[0];
      end
      rau_pkg::CMD_POW_MUL_N: begin rn_r <= sat_val; rnb_r <= sat_big; end
      rau_pkg::CMD_POW_MUL_D: begin rd_r <= sat_val; rdb_r <= sat_big; end
      rau_pkg::CMD_POW_SQ_N:  begin pn_r <= sat_val; pnb_r <= sat_big; end
      rau_pkg::CMD_POW_SQ_D: begin
        pd_r <= sat_val; pdb_r <= sat_big; e_r <= e_r >> 1;
      end
      rau_pkg::CMD_POW_FIN: begin
        x_r <= {32'd0, rn_r};
        if (rn_r == 32'd0) begin
          y_r <= 64'd1; big_r <= 1'b0;
        end else begin
          y_r <= {32'd0, rd_r}; big_r <= rnb_r | rdb_r;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == rau_pkg::CMD_FINAL) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == rau_pkg::CMD_FINAL) begin
      status_r <= st;
      eq_o_r   <= (st == rau_pkg::ST_OK) && (op_r == rau_pkg::OP_CMP) && eq_r;
      lt_o_r   <= (st == rau_pkg::ST_OK) && (op_r == rau_pkg::OP_CMP) && lt_r;
      if ((st != rau_pkg::ST_OK) || (op_r == rau_pkg::OP_CMP)) begin
        res_num_r <= 32'd0; res_den_r <= 31'd0; is_int_r <= 1'b0;
      end else begin
        res_num_r <= neg_r ? (32'd0 - x_r[31:0]) : x_r[31:0];
        res_den_r <= y_r[30:0];
        is_int_r  <= (y_r == 64'd1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res_num    = res_num_r;
  assign out_res_den    = res_den_r;
  assign out_is_integer = is_int_r;
  assign out_equal      = eq_o_r;
  assign out_less       = lt_o_r;
  assign out_status     = status_r;

  // status to controller
  assign stat.op       = op_r;
  assign stat.early    = zden | divz;
  assign stat.x_zero   = (x_r == 64'd0);
  assign stat.g_eq     = (u_r == v_r);
  assign stat.g_one    = (u_r == v_r) && (u_r == 64'd1) && (k_r == 6'd0);
  assign stat.div_last = (cnt_r == 6'h3F);
  assign stat.e_zero   = (e_r == 32'd0);
  assign stat.e_lsb    = e_r[0];
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

[verif/rau_result_checker.sv]
module rau_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  input  logic signed [31:0] in_exponent,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_res_num,
  input  logic [30:0]        out_res_den,
  input  logic               out_is_integer,
  input  logic               out_equal,
  input  logic               out_less,
  input  logic [1:0]         out_status,
  output int                 error_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               is_int;
    logic               eq;
    logic               lt;
    logic [1:0]         st;
  } rat_result_t;

  localparam u64_t SAT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam u64_t LIM     = 64'h8000_0000;

  rat_result_t expected_q[$];

  assign pending_count = expected_q.size();

  function automatic u64_t mag32(logic [31:0] x);
    return x[31] ? (64'h1_0000_0000 - u64_t'(x)) : u64_t'(x);
  endfunction

  function automatic u64_t gcd64(u64_t a, u64_t b);
    u64_t t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void reduce_frac(input bit n, input u64_t m, input u64_t d,
                                      output bit rn, output u64_t rm, output u64_t rd);
    u64_t g;
    if (m == 0) begin
      rn = 0;
      rm = 0;
      rd = 1;
    end else begin
      g  = gcd64(m, d);
      rn = n;
      rm = m / g;
      rd = d / g;
    end
  endfunction

  function automatic u64_t sat_mul(u64_t a, u64_t b);
    if (a != 0 && b > SAT_MAX / a) return SAT_MAX;
    return a * b;
  endfunction

  function automatic u64_t pow_sat(u64_t base, u64_t e);
    u64_t r;
    r = 1;
    while (e != 0) begin
      if (e[0]) r = sat_mul(r, base);
      base = sat_mul(base, base);
      e >>= 1;
    end
    return r;
  endfunction

  // signed-magnitude add, magnitudes below 2^63
  function automatic void sm_add(input bit sa, input u64_t ma, input bit sb, input u64_t mb,
                                 output bit sr, output u64_t mr);
    if (sa == sb) begin
      sr = sa;
      mr = ma + mb;
    end else if (ma >= mb) begin
      sr = sa;
      mr = ma - mb;
    end else begin
      sr = sb;
      mr = mb - ma;
    end
    if (mr == 0) sr = 0;
  endfunction

  function automatic rat_result_t predict_rational(logic [2:0] op, logic [31:0] an_w,
      logic [31:0] ad_w, logic [31:0] bn_w, logic [31:0] bd_w, logic [31:0] ex_w);
    rat_result_t res;
    u64_t an, ad, bn, bd, em, am, adn, bm, bdn, rm, rd, m1, pb, pd;
    bit an_s, ad_s, bn_s, bd_s, a_neg, b_neg, rneg, s1, sb, fit;
    logic [1:0] st;
    bit is_cmp, uses_b, eq, lt;
    an = mag32(an_w); an_s = an_w[31];
    ad = mag32(ad_w); ad_s = ad_w[31];
    bn = mag32(bn_w); bn_s = bn_w[31];
    bd = mag32(bd_w); bd_s = bd_w[31];
    em = mag32(ex_w);
    is_cmp = (op == rau_pkg::OP_CMP);
    uses_b = (op >= rau_pkg::OP_ADD && op <= rau_pkg::OP_CMP);
    st = rau_pkg::ST_OK;
    eq = 0;
    lt = 0;
    rneg = 0; rm = 0; rd = 1;
    if (ad == 0 || (uses_b && bd == 0)) begin
      st = rau_pkg::ST_ZDEN;
    end else begin
      reduce_frac(an_s != ad_s, an, ad, a_neg, am, adn);
      reduce_frac(bn_s != bd_s, bn, (bd == 0) ? 1 : bd, b_neg, bm, bdn);
      case (op)
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          sb = (op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
          if (bm == 0) sb = 0;
          sm_add(a_neg, am * bdn, sb, bm * adn, s1, m1);
          reduce_frac(s1, m1, adn * bdn, rneg, rm, rd);
        end
        rau_pkg::OP_MUL: reduce_frac(a_neg != b_neg, am * bm, adn * bdn, rneg, rm, rd);
        rau_pkg::OP_DIV: begin
          if (bm == 0) st = rau_pkg::ST_DIVZ;
          else reduce_frac(a_neg != b_neg, am * bdn, adn * bm, rneg, rm, rd);
        end
        rau_pkg::OP_CMP: begin
          sm_add(a_neg, am * bdn, (bm == 0) ? 1'b0 : !b_neg, bm * adn, s1, m1);
          eq = (m1 == 0);
          lt = (m1 != 0) && s1;
        end
        rau_pkg::OP_POW: begin
          pb = am;
          pd = adn;
          if (ex_w[31]) begin
            if (am == 0) st = rau_pkg::ST_DIVZ;
            pb = adn;
            pd = am;
          end
          if (st == rau_pkg::ST_OK) begin
            rneg = a_neg && em[0];
            rm = pow_sat(pb, em);
            rd = pow_sat(pd, em);
            if (rm == 0) begin
              rneg = 0;
              rd = 1;
            end
          end
        end
        default: begin
          rneg = a_neg; rm = am; rd = adn;
        end
      endcase
      if (st == rau_pkg::ST_OK && !is_cmp) begin
        fit = (rd != 0) && (rd <= LIM - 1) && (rneg ? (rm <= LIM) : (rm <= LIM - 1));
        if (!fit) st = rau_pkg::ST_OVF;
      end
    end
    if (st != rau_pkg::ST_OK || is_cmp) begin
      res.num = '0;
      res.den = '0;
      res.is_int = 0;
    end else begin
      res.num = rneg ? (32'd0 - rm[31:0]) : rm[31:0];
      res.den = rd[30:0];
      res.is_int = (rd == 1);
    end
    res.eq = (st == rau_pkg::ST_OK) && eq;
    res.lt = (st == rau_pkg::ST_OK) && lt;
    res.st = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    rat_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_q.push_back(predict_rational(in_opcode, in_a_num, in_a_den, in_b_num,
                                              in_b_den, in_exponent));
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("MISMATCH %0t: result beat with nothing expected", $realtime);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_res_num !== want.num) report_mismatch("res_num", out_res_num, want.num);
          if (out_res_den !== want.den) report_mismatch("res_den", out_res_den, want.den);
          if (out_is_integer !== want.is_int)
            report_mismatch("is_integer", out_is_integer, want.is_int);
          if (out_equal !== want.eq) report_mismatch("equal", out_equal, want.eq);
          if (out_less !== want.lt) report_mismatch("less", out_less, want.lt);
          if (out_status !== want.st) report_mismatch("status", out_status, want.st);
        end
      end
    end
  end

endmodule

[verif/rational_arithmetic_unit_tb.sv]
module rational_arithmetic_unit_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_opcode;
  logic signed [31:0] in_a_num;
  logic signed [31:0] in_a_den;
  logic signed [31:0] in_b_num;
  logic signed [31:0] in_b_den;
  logic signed [31:0] in_exponent;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic               out_is_integer;
  logic               out_equal;
  logic               out_less;
  logic [1:0]         out_status;

  int error_count;
  int pending_count;
  int result_count;
  int sent_count;
  int idle_pct;
  int stall_pct;

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;

  rational_arithmetic_unit dut (.*);

  rau_result_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("timeout");
    $display("rational_arithmetic_unit_tb: done, errors");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one input beat, with random idle cycles before it
  task automatic send_item(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, logic [31:0] ex);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_a_num    <= an;
    in_a_den    <= ad;
    in_b_num    <= bn;
    in_b_den    <= bd;
    in_exponent <= ex;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40) - 20;
      1: v = $urandom;
      2: case ($urandom_range(0, 4))
           0: v = 0;
           1: v = 1;
           2: v = NEG1;
           3: v = MAXP;
           default: v = MINN;
         endcase
      3: v = $urandom_range(0, 1) ? -$urandom_range(0, 65535) : $urandom_range(0, 65535);
      default: v = $urandom_range(0, 2000) - 1000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_den();
    logic [31:0] v;
    if ($urandom_range(0, 19) == 0) return 0;
    v = rand_word();
    return (v == 0) ? 32'd1 : v;
  endfunction

  function automatic logic [31:0] rand_exp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MINN : MAXP;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom_range(0, 16) - 8;
    endcase
  endfunction

  task automatic random_items(int n);
    logic [2:0]  op;
    logic [31:0] an, ad;
    repeat (n) begin
      op = 3'($urandom_range(0, 7));
      an = rand_word();
      ad = rand_den();
      // unit bases make huge exponents meaningful
      if (op == rau_pkg::OP_POW && $urandom_range(0, 3) == 0) begin
        an = $urandom_range(0, 1) ? NEG1 : 32'd1;
        ad = $urandom_range(0, 1) ? NEG1 : 32'd1;
      end
      send_item(op, an, ad, rand_word(), rand_den(), rand_exp());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= rau_pkg::OP_REDUCE;
    in_a_num    <= '0;
    in_a_den    <= 32'd1;
    in_b_num    <= '0;
    in_b_den    <= 32'd1;
    in_exponent <= '0;
    sent_count  = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats
    send_item(rau_pkg::OP_REDUCE, 6, -4, 0, 1, 0);
    send_item(rau_pkg::OP_REDUCE, 5, 0, 0, 1, 0);            // zero denominator
    send_item(rau_pkg::OP_REDUCE, MINN, NEG1, 0, 0, 0);       // magnitude too big
    send_item(rau_pkg::OP_REDUCE, MINN, 1, 0, 0, 0);
    send_item(rau_pkg::OP_REDUCE, 0, -5, 3, 7, 0);
    send_item(rau_pkg::OP_ADD, 1, 2, 1, 3, 0);
    send_item(rau_pkg::OP_ADD, 3, 4, 1, 0, 0);               // zero b denominator
    send_item(rau_pkg::OP_ADD, MAXP, 1, MAXP, 1, 0);          // overflow
    send_item(rau_pkg::OP_SUB, 2, 5, -2, -5, 0);              // zero result
    send_item(rau_pkg::OP_MUL, MINN, 1, NEG1, 1, 0);
    send_item(rau_pkg::OP_MUL, -3, 7, 14, 9, 0);
    send_item(rau_pkg::OP_DIV, 3, 4, 0, 5, 0);                // division by zero
    send_item(rau_pkg::OP_DIV, 0, 0, 0, 0, 0);                // zero den wins
    send_item(rau_pkg::OP_DIV, -3, 4, 9, -8, 0);
    send_item(rau_pkg::OP_CMP, 1, 2, 2, 4, 0);
    send_item(rau_pkg::OP_CMP, -1, 3, 1, 3, 0);
    send_item(rau_pkg::OP_CMP, MAXP, 1, MINN, 1, 0);
    send_item(rau_pkg::OP_CMP, 1, 2, 1, 0, 0);
    send_item(rau_pkg::OP_POW, 2, 3, 0, 0, 5);
    send_item(rau_pkg::OP_POW, -2, 3, 0, 0, -3);
    send_item(rau_pkg::OP_POW, 0, 7, 0, 0, 0);                // zero to the zeroth
    send_item(rau_pkg::OP_POW, 0, 7, 0, 0, NEG1);             // zero to a negative power
    send_item(rau_pkg::OP_POW, 2, 1, 0, 0, 31);
    send_item(rau_pkg::OP_POW, 1, NEG1, 0, 0, MINN);
    send_item(3'd7, -9, 6, 0, 0, 0);
    drain();

    // random phases: none, sender idle, receiver stall, both
    random_items(175);
    drain();                                        // sender waits for every result
    idle_pct = 49;
    random_items(175);
    idle_pct  = 0;
    stall_pct = 49;
    random_items(175);
    idle_pct  = 10;
    stall_pct = 10;
    random_items(175);
    drain();
    repeat (500) @(posedge clk);

    $display("covered %0d input beats over all opcodes, %0d results checked", sent_count,
             result_count);
    $display("idle and stall phases on both channels, %0d mismatches", error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("rational_arithmetic_unit_tb: done, clean");
    end else begin
      $display("rational_arithmetic_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
